// ----- design/kvt_pkg.sv -----
package kvt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int HALF_WIDTH  = 32;
  localparam int FIELD_W     = 32;
  localparam int HELD_W      = 5;
  localparam int LIMIT_W     = 5;

  localparam logic [1:0] MODE_GET    = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  typedef logic [HALF_WIDTH-1:0] half_t;

  typedef struct packed {
    half_t first;
    half_t second;
  } pair_t;

  // Search token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic  active;
    logic  hit;
    logic  free;
    pair_t value;
  } probe_t;

  typedef enum logic [1:0] {
    CMT_NONE,
    CMT_CLEAR,
    CMT_UPDATE,
    CMT_FILL
  } cmt_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [FIELD_W-1:0] key_first;
    logic signed [FIELD_W-1:0] key_second;
    logic signed [FIELD_W-1:0] value_first;
    logic signed [FIELD_W-1:0] value_second;
  } in_item_t;

  typedef struct packed {
    logic                      success;
    logic signed [FIELD_W-1:0] found_first;
    logic signed [FIELD_W-1:0] found_second;
    logic [HELD_W-1:0]         entries_held;
  } out_item_t;

  function automatic logic signed [FIELD_W-1:0] sext_half(input half_t v);
    logic signed [HALF_WIDTH-1:0] s;
    s = $signed(v);
    return FIELD_W'(s);
  endfunction

endpackage

// ----- design/kvt_cell.sv -----
module kvt_cell
  import kvt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  pair_t   key_in,
  input  pair_t   value_in,
  input  logic    in_range,
  input  probe_t  probe_in,
  output probe_t  probe_out,
  input  cmt_op_t cmd,
  output logic    slot_valid
);

  logic   valid_r, valid_nxt;
  logic   sel_hit_r, sel_hit_nxt;
  logic   sel_free_r, sel_free_nxt;
  pair_t  key_r, key_nxt;
  pair_t  value_r, value_nxt;
  probe_t probe_r, probe_nxt;
  logic   match;
  logic   is_free;

  assign match   = valid_r && in_range && (key_r == key_in);
  assign is_free = !valid_r && in_range;

  always_comb begin
    probe_nxt        = probe_in;
    probe_nxt.hit    = probe_in.hit | match;
    probe_nxt.free   = probe_in.free | is_free;
    if (!probe_in.hit && match) begin
      probe_nxt.value = value_r;
    end
    if (!probe_in.active) begin
      probe_nxt = '0;
    end

    // Lowest match / lowest free slot claims the commit.
    sel_hit_nxt  = probe_in.active ? (match && !probe_in.hit) : sel_hit_r;
    sel_free_nxt = probe_in.active ? (is_free && !probe_in.free) : sel_free_r;

    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    case (cmd)
      CMT_CLEAR: begin
        if (sel_hit_r) valid_nxt = 1'b0;
      end
      CMT_UPDATE: begin
        if (sel_hit_r) value_nxt = value_in;
      end
      CMT_FILL: begin
        if (sel_free_r) begin
          valid_nxt = 1'b1;
          key_nxt   = key_in;
          value_nxt = value_in;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      sel_hit_r  <= 1'b0;
      sel_free_r <= 1'b0;
      probe_r    <= '0;
    end else begin
      valid_r    <= valid_nxt;
      sel_hit_r  <= sel_hit_nxt;
      sel_free_r <= sel_free_nxt;
      probe_r    <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign probe_out  = probe_r;
  assign slot_valid = valid_r;

endmodule

// ----- design/fixed_capacity_key_value_table_core.sv -----
// Key/value table with a two-half key and a two-half value per slot.
// Input channel in_valid/in_ready/in_data carries one request (get, add,
// remove); output channel out_valid/out_ready/out_data returns one result
// per request. The slot limit register sits at byte address 0 of the APB
// port (psel/penable/pwrite/paddr/pwdata/prdata/pready, pready tied high).
// A request is held while a search token walks the row of slot cells, one
// cell per cycle; the lowest matching and lowest free slot latch a claim.
// After the token leaves the last cell the update is committed and the
// result loaded into the output register.
// A new request is taken only after the previous one has walked the cell
// chain and been committed; in_ready is high only while idle.
// A finished result waits in the output register; if it has not been
// taken when the next request completes its walk, that request holds in
// the commit step until out_ready frees the register.
// Reset (rst_n low, synchronous) empties the table, zeroes the entry count
// and sets the slot limit to 16.
module fixed_capacity_key_value_table_core
  import kvt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t             st_r, st_nxt;
  in_item_t           req_r, req_nxt;
  logic               start_r;
  logic               res_hit_r, res_hit_nxt;
  logic               res_free_r, res_free_nxt;
  pair_t              res_value_r, res_value_nxt;
  logic [HELD_W-1:0]  held_r, held_nxt;
  logic [LIMIT_W-1:0] slots_r;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  cmt_op_t            cmd;

  probe_t                 chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] in_range;
  logic [TABLE_DEPTH-1:0] valid_vec;
  pair_t                  req_key;
  pair_t                  req_value;
  logic                   in_fire;
  logic                   cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = paddr[2] ? 32'd0 : 32'(slots_r);
  assign in_ready = (st_r == ST_IDLE);
  assign in_fire = in_valid && in_ready;

  assign req_key.first    = req_r.key_first[HALF_WIDTH-1:0];
  assign req_key.second   = req_r.key_second[HALF_WIDTH-1:0];
  assign req_value.first  = req_r.value_first[HALF_WIDTH-1:0];
  assign req_value.second = req_r.value_second[HALF_WIDTH-1:0];

  always_comb begin
    chain[0]        = '0;
    chain[0].active = start_r;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    assign in_range[g] = (32'(g) < 32'(slots_r));

    kvt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .key_in     (req_key),
      .value_in   (req_value),
      .in_range   (in_range[g]),
      .probe_in   (chain[g]),
      .probe_out  (chain[g+1]),
      .cmd        (cmd),
      .slot_valid (valid_vec[g])
    );
  end

  always_comb begin
    st_nxt        = st_r;
    req_nxt       = req_r;
    res_hit_nxt   = res_hit_r;
    res_free_nxt  = res_free_r;
    res_value_nxt = res_value_r;
    held_nxt      = held_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = CMT_NONE;

    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt = in_data;
          st_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain[TABLE_DEPTH].active) begin
          res_hit_nxt   = chain[TABLE_DEPTH].hit;
          res_free_nxt  = chain[TABLE_DEPTH].free;
          res_value_nxt = chain[TABLE_DEPTH].value;
          st_nxt        = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = '0;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
          if (req_r.mode == MODE_GET || req_r.mode == MODE_REMOVE) begin
            if (res_hit_r) begin
              out_nxt.success      = 1'b1;
              out_nxt.found_first  = sext_half(res_value_r.first);
              out_nxt.found_second = sext_half(res_value_r.second);
              if (req_r.mode == MODE_REMOVE) begin
                cmd = CMT_CLEAR;
                if (held_r != '0) held_nxt = held_r - HELD_W'(1);
              end
            end
          end else if (req_r.mode == MODE_ADD) begin
            if (res_hit_r) begin
              cmd             = CMT_UPDATE;
              out_nxt.success = 1'b1;
            end else if (res_free_r) begin
              cmd             = CMT_FILL;
              out_nxt.success = 1'b1;
              held_nxt        = held_r + HELD_W'(1);
            end
          end
          out_nxt.entries_held = held_nxt;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      start_r     <= 1'b0;
      held_r      <= '0;
      slots_r     <= LIMIT_W'(16);
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      start_r     <= in_fire;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && !paddr[2]) begin
        slots_r <= pwdata[LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    res_hit_r   <= res_hit_nxt;
    res_free_r  <= res_free_nxt;
    res_value_r <= res_value_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    32'(held_r) == $countones(valid_vec))
    else $error("entry count disagrees with slot valid bits");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(held_r) <= TABLE_DEPTH)
    else $error("entry count above table depth");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_COMMIT)
    else $error("result appeared outside commit");

  a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chain[TABLE_DEPTH].active |-> st_r == ST_SCAN)
    else $error("search token left chain outside scan");

endmodule
